/* rtl/arp_rr_pkg.sv */
// Package for the ARP request responder: field types, protocol constants
// and configuration register indexes.
// No dependencies.
package arp_rr_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] half_type;
   typedef logic [47:0] mac_type;
   typedef logic [31:0] ip_type;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_MAC = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_IP  = 1'd1;

   // byte counter and frame sizes
   localparam int COUNT_W   = 5;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
   localparam int ARP_MIN_LEN = 28;
   localparam int FRAME_LEN   = 42;
   localparam int TX_IDX_W    = 6;

   // ARP payload offsets (first byte of each field)
   localparam logic [COUNT_W-1:0] OFS_HTYPE = 5'd0;
   localparam logic [COUNT_W-1:0] OFS_PTYPE = 5'd2;
   localparam logic [COUNT_W-1:0] OFS_OPER  = 5'd6;
   localparam logic [COUNT_W-1:0] OFS_SHA   = 5'd8;
   localparam logic [COUNT_W-1:0] OFS_SPA   = 5'd14;
   localparam logic [COUNT_W-1:0] OFS_THA   = 5'd18;
   localparam logic [COUNT_W-1:0] OFS_TPA   = 5'd24;
   localparam logic [COUNT_W-1:0] OFS_END   = 5'd28;
   // offset of the byte that completes a minimum-length payload
   localparam logic [COUNT_W-1:0] OFS_FINAL = 5'd27;

   // protocol values
   localparam half_type ETHERTYPE_ARP = 16'h0806;
   localparam half_type HTYPE_ETH     = 16'h0001;
   localparam half_type PTYPE_IPV4    = 16'h0800;
   localparam byte_type HLEN_ETH      = 8'h06;
   localparam byte_type PLEN_IPV4     = 8'h04;
   localparam half_type OPER_REQUEST  = 16'h0001;
   localparam half_type OPER_REPLY    = 16'h0002;

endpackage

/* rtl/arp_rr_ifs.sv */
// Stream interfaces for the ARP request responder: received payload bytes
// in, reply frame bytes out. Depends on arp_rr_pkg.
interface arp_rr_req_if;
   import arp_rr_pkg::*;
   logic     valid;
   logic     ready;
   byte_type in_byte;
   logic     in_last;
   modport source (output valid, in_byte, in_last, input ready);
   modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface arp_rr_rsp_if;
   import arp_rr_pkg::*;
   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     out_last;
   modport source (output valid, out_byte, out_last, input ready);
   modport sink   (input valid, out_byte, out_last, output ready);
endinterface

/* rtl/arp_request_responder_top.sv */
// ARP request responder, top level: payload parser, reply serialiser and
// output register. Depends on arp_rr_pkg and the interfaces in arp_rr_ifs.sv.
//
// Takes one ARP payload byte per cycle and answers a valid request for
// own_ip with a 42-byte Ethernet reply frame sent one byte per cycle. Fields
// are captured as bytes arrive; the checks run on the final byte and, when
// they pass, sender MAC and IP are copied into the serialiser so that the
// next packet can be parsed while the reply goes out. A packet byte at
// payload offset 27 or later is held off (req_chan.ready low) while an
// earlier reply is still being serialised, as only such a byte can start a
// new reply; otherwise one request is taken every cycle. Output
// backpressure stalls the serialiser only. Configuration writes take effect
// on the next cycle and are expected only while the block is idle.
module arp_request_responder_top (
   input  logic                                clock,
   input  logic                                reset,
   arp_rr_req_if.sink                          req_chan,
   arp_rr_rsp_if.source                        rsp_chan,
   input  logic                                csr_we,
   input  logic [arp_rr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [arp_rr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import arp_rr_pkg::*;

   // configuration
   mac_type own_mac_ff;
   ip_type  own_ip_ff;

   // parser state
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   half_type           hw_type_ff, hw_type_in;
   half_type           proto_type_ff, proto_type_in;
   half_type           operation_ff, operation_in;
   mac_type            sender_mac_ff, sender_mac_in;
   ip_type             sender_ip_ff, sender_ip_in;
   ip_type             target_ip_ff, target_ip_in;

   // serialiser
   logic                tx_busy_ff, tx_busy_in;
   logic [TX_IDX_W-1:0] tx_idx_ff, tx_idx_in;
   mac_type             tx_mac_ff;
   ip_type              tx_ip_ff;

   // output register
   logic     rsp_valid_ff, rsp_valid_in;
   byte_type rsp_byte_ff;
   logic     rsp_last_ff;

   logic                  req_accept;
   logic                  reply_ok;
   logic                  tx_start;
   logic                  out_load;
   logic                  tx_done;
   logic [FRAME_LEN*8-1:0] frame;
   byte_type              frame_byte;

   assign req_chan.ready = !tx_busy_ff || (byte_count_ff < OFS_FINAL);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // ---------------------------------------------------------------- parser
   always_comb begin
      hw_type_in    = hw_type_ff;
      proto_type_in = proto_type_ff;
      operation_in  = operation_ff;
      sender_mac_in = sender_mac_ff;
      sender_ip_in  = sender_ip_ff;
      target_ip_in  = target_ip_ff;
      if (byte_count_ff < OFS_PTYPE) begin
         hw_type_in = {hw_type_ff[7:0], req_chan.in_byte};
      end else if (byte_count_ff < 5'd4) begin
         proto_type_in = {proto_type_ff[7:0], req_chan.in_byte};
      end else if (byte_count_ff >= OFS_OPER && byte_count_ff < OFS_SHA) begin
         operation_in = {operation_ff[7:0], req_chan.in_byte};
      end else if (byte_count_ff >= OFS_SHA && byte_count_ff < OFS_SPA) begin
         sender_mac_in = {sender_mac_ff[39:0], req_chan.in_byte};
      end else if (byte_count_ff >= OFS_SPA && byte_count_ff < OFS_THA) begin
         sender_ip_in = {sender_ip_ff[23:0], req_chan.in_byte};
      end else if (byte_count_ff >= OFS_TPA && byte_count_ff < OFS_END) begin
         target_ip_in = {target_ip_ff[23:0], req_chan.in_byte};
      end

      if (req_chan.in_last) begin
         byte_count_in = '0;
      end else if (byte_count_ff == COUNT_MAX) begin
         byte_count_in = COUNT_MAX;
      end else begin
         byte_count_in = byte_count_ff + 1'b1;
      end

      // length >= 28 means this byte sits at offset 27 or beyond
      reply_ok = (byte_count_ff >= OFS_FINAL) &&
                 (hw_type_in == HTYPE_ETH) &&
                 (proto_type_in == PTYPE_IPV4) &&
                 (operation_in == OPER_REQUEST) &&
                 (target_ip_in == own_ip_ff);
   end

   assign tx_start = req_accept && req_chan.in_last && reply_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         hw_type_ff    <= '0;
         proto_type_ff <= '0;
         operation_ff  <= '0;
         sender_mac_ff <= '0;
         sender_ip_ff  <= '0;
         target_ip_ff  <= '0;
      end else if (req_accept) begin
         byte_count_ff <= byte_count_in;
         hw_type_ff    <= hw_type_in;
         proto_type_ff <= proto_type_in;
         operation_ff  <= operation_in;
         sender_mac_ff <= sender_mac_in;
         sender_ip_ff  <= sender_ip_in;
         target_ip_ff  <= target_ip_in;
      end
   end

   // --------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= '0;
         own_ip_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_MAC: own_mac_ff <= csr_wdata;
            CSR_OWN_IP:  own_ip_ff  <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ serialiser
   assign frame = {tx_mac_ff, own_mac_ff, ETHERTYPE_ARP,
                   HTYPE_ETH, PTYPE_IPV4, HLEN_ETH, PLEN_IPV4, OPER_REPLY,
                   own_mac_ff, own_ip_ff, tx_mac_ff, tx_ip_ff};
   assign frame_byte = frame[(FRAME_LEN*8-1) - 8*tx_idx_ff -: 8];

   assign out_load = tx_busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign tx_done  = out_load && (tx_idx_ff == TX_IDX_W'(FRAME_LEN - 1));

   always_comb begin
      tx_busy_in = tx_busy_ff;
      tx_idx_in  = tx_idx_ff;
      if (tx_start) begin
         tx_busy_in = 1'b1;
         tx_idx_in  = '0;
      end else if (tx_done) begin
         tx_busy_in = 1'b0;
         tx_idx_in  = '0;
      end else if (out_load) begin
         tx_idx_in = tx_idx_ff + 1'b1;
      end
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_busy_ff   <= 1'b0;
         tx_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tx_busy_ff   <= tx_busy_in;
         tx_idx_ff    <= tx_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // snapshot of the requester, so the next packet may overwrite the parser
   always_ff @(posedge clock) begin
      if (tx_start) begin
         tx_mac_ff <= sender_mac_in;
         tx_ip_ff  <= sender_ip_in;
      end
      if (out_load) begin
         rsp_byte_ff <= frame_byte;
         rsp_last_ff <= tx_done;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.out_last = rsp_last_ff;

   // ------------------------------------------------------------ assertions
   a_no_start_while_busy: assert property (@(posedge clock) disable iff (reset)
      tx_start |-> !tx_busy_ff)
      else $error("reply started while previous reply still serialising");

   a_tx_idx_range: assert property (@(posedge clock) disable iff (reset)
      tx_idx_ff <= TX_IDX_W'(FRAME_LEN - 1))
      else $error("serialiser index beyond frame length");

   a_idle_serialiser: assert property (@(posedge clock) disable iff (reset)
      !tx_busy_ff |-> (tx_idx_ff == '0))
      else $error("serialiser index not cleared while idle");

   // checked on the first cycle out of reset, once the reset edge has landed
   a_reset_clears: assert property (@(posedge clock)
      ($past(reset) === 1'b1) && (reset === 1'b0) |->
         (byte_count_ff == '0) && !rsp_valid_ff && !tx_busy_ff)
      else $error("control state not cleared by reset");

endmodule

/* dv/tb_arp_request_responder_top.sv */
// Testbench for arp_request_responder_top: feeds ARP payloads, predicts the
// 42-byte reply frames and checks every reply byte in order.
// Depends on arp_rr_pkg, the stream interfaces in arp_rr_ifs.sv and the RTL.
module tb_arp_request_responder_top;
   timeunit 1ns;
   timeprecision 1ps;
   import arp_rr_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE       = 10;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_ITEMS  = 25;

   typedef struct packed {
      byte_type data;
      logic     last;
   } frame_byte_t;

   // Tracks the parser state and holds the reply bytes still to come.
   class reply_scoreboard;
      mac_type            own_mac;
      ip_type             own_ip;
      logic [COUNT_W-1:0] count;
      half_type           hw, pt, op;
      mac_type            sha;
      ip_type             spa, tpa;
      frame_byte_t        frame_q[$];
      int                 errors;
      int                 frames;

      function new();
         own_mac = '0;
         own_ip  = '0;
         count   = '0;
         hw      = '0;
         pt      = '0;
         op      = '0;
         sha     = '0;
         spa     = '0;
         tpa     = '0;
         errors  = 0;
         frames  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_OWN_MAC) begin
            own_mac = value;
         end else if (idx == CSR_OWN_IP) begin
            own_ip = value[31:0];
         end
      endfunction

      function int pending();
         return frame_q.size();
      endfunction

      function void push_field(logic [47:0] value, int nbytes);
         for (int i = nbytes - 1; i >= 0; i--)
            frame_q.push_back(frame_byte_t'{data: value[8*i +: 8], last: 1'b0});
      endfunction

      function void note_request(byte_type b, logic last);
         logic [COUNT_W-1:0] len;
         if (count < OFS_PTYPE) begin
            hw = {hw[7:0], b};
         end else if (count < OFS_PTYPE + 2) begin
            pt = {pt[7:0], b};
         end else if (count >= OFS_OPER && count < OFS_SHA) begin
            op = {op[7:0], b};
         end else if (count >= OFS_SHA && count < OFS_SPA) begin
            sha = {sha[39:0], b};
         end else if (count >= OFS_SPA && count < OFS_THA) begin
            spa = {spa[23:0], b};
         end else if (count >= OFS_TPA && count < OFS_END) begin
            tpa = {tpa[23:0], b};
         end
         len = (count == COUNT_MAX) ? COUNT_MAX : count + 1'b1;
         if (!last) begin
            count = len;
            return;
         end
         count = '0;
         if (len < ARP_MIN_LEN || hw != HTYPE_ETH || pt != PTYPE_IPV4 ||
             op != OPER_REQUEST || tpa != own_ip)
            return;
         push_field(sha, 6);
         push_field(own_mac, 6);
         push_field(ETHERTYPE_ARP, 2);
         push_field(HTYPE_ETH, 2);
         push_field(PTYPE_IPV4, 2);
         push_field(HLEN_ETH, 1);
         push_field(PLEN_IPV4, 1);
         push_field(OPER_REPLY, 2);
         push_field(own_mac, 6);
         push_field(own_ip, 4);
         push_field(sha, 6);
         push_field(spa, 4);
         frame_q[frame_q.size() - 1].last = 1'b1;
         frames++;
      endfunction

      function void check_reply(byte_type b, logic last);
         frame_byte_t want;
         if (frame_q.size() == 0) begin
            $display("%0t: reply byte %02h (last %0b) with none expected", $time, b, last);
            errors++;
            return;
         end
         want = frame_q.pop_front();
         if (b !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, b);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: out_last expected %0b actual %0b", $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   arp_rr_req_if req_chan();
   arp_rr_rsp_if rsp_chan();

   reply_scoreboard sb = new();
   bit      calm = 1'b0;
   int      rsp_hold = 0;
   int      idle_cycles = 0;
   int      items = 0;
   mac_type mac_cfg = '0;
   ip_type  ip_cfg = '0;

   arp_request_responder_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // reply side back-pressure
   initial rsp_chan.ready = 1'b0;
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold       <= rsp_hold - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         rsp_hold       <= pick_gap();
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         sb.check_reply(rsp_chan.out_byte, rsp_chan.out_last);
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The request is noted here rather than in a monitor so that the
   // expectation exists before any drain check in the same step.
   task automatic send_request(input byte_type b, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.in_last <= last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_request(b, last);
      items++;
   endtask

   task automatic send_packet(input byte_type pkt[$]);
      foreach (pkt[i])
         send_request(pkt[i], i == pkt.size() - 1);
   endtask

   function automatic void append(ref byte_type pkt[$], input logic [47:0] value,
                                  input int nbytes);
      for (int i = nbytes - 1; i >= 0; i--)
         pkt.push_back(value[8*i +: 8]);
   endfunction

   task automatic send_arp(input half_type htype, input half_type ptype,
                           input half_type oper, input mac_type sha, input ip_type spa,
                           input ip_type tpa, input int len);
      byte_type pkt[$];
      append(pkt, htype, 2);
      append(pkt, ptype, 2);
      // length bytes are never checked, so vary them now and then
      if ($urandom_range(0, 1)) append(pkt, {HLEN_ETH, PLEN_IPV4}, 2);
      else append(pkt, 16'($urandom), 2);
      append(pkt, oper, 2);
      append(pkt, sha, 6);
      append(pkt, spa, 4);
      append(pkt, 48'({$urandom, $urandom}), 6);
      append(pkt, tpa, 4);
      while (pkt.size() < len) pkt.push_back(8'($urandom));
      while (pkt.size() > len) void'(pkt.pop_back());
      send_packet(pkt);
   endtask

   task automatic send_random_packet();
      int       kind, len;
      half_type htype, ptype, oper;
      ip_type   tpa;
      byte_type pkt[$];
      htype = HTYPE_ETH;
      ptype = PTYPE_IPV4;
      oper  = OPER_REQUEST;
      tpa   = ip_cfg;
      kind  = $urandom_range(0, 99);
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 44) : $urandom_range(28, 30);
      if (kind >= 93) begin
         // plain noise
         len = $urandom_range(1, 40);
         repeat (len) pkt.push_back(8'($urandom));
         send_packet(pkt);
         return;
      end
      if (kind >= 84) begin
         len = $urandom_range(1, 27);
      end else if (kind >= 76) begin
         tpa ^= 32'd1 << $urandom_range(0, 31);
      end else if (kind >= 69) begin
         oper = $urandom_range(0, 1) ? OPER_REPLY : 16'($urandom_range(2, 16'hFFFF));
      end else if (kind >= 62) begin
         ptype ^= 16'($urandom_range(1, 16'hFFFF));
      end else if (kind >= 55) begin
         htype ^= 16'($urandom_range(1, 16'hFFFF));
      end
      send_arp(htype, ptype, oper, 48'({$urandom, $urandom}), $urandom, tpa, len);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic program_regs(input mac_type mac, input ip_type ip);
      mac_cfg = mac;
      ip_cfg  = ip;
      csr_write(CSR_OWN_MAC, mac);
      // junk in the upper bits must be dropped
      csr_write(CSR_OWN_IP, {16'($urandom), ip});
      csr_we <= 1'b0;
   endtask

   task automatic drain(input int settle);
      req_chan.valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   initial begin
      int start;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = '0;
      req_chan.in_last = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_OWN_MAC;
      csr_wdata        = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      program_regs('1, '1);
      send_arp(HTYPE_ETH, PTYPE_IPV4, OPER_REQUEST, '1, '1, ip_cfg, 28);
      send_request(8'hFF, 1'b1);
      send_arp(HTYPE_ETH, PTYPE_IPV4, OPER_REQUEST, '1, '1, ip_cfg, 27);
      // long enough to saturate the byte count
      send_arp(HTYPE_ETH, PTYPE_IPV4, OPER_REQUEST, '0, '0, ip_cfg, 34);
      drain(SETTLE);

      for (int phase = 1; phase <= 5; phase++) begin
         case (phase)
            1: program_regs('0, '0);
            3: program_regs(48'hAAAA_AAAA_AAAA, 32'h5555_5555);
            default: program_regs(48'({$urandom, $urandom}), $urandom);
         endcase
         calm  = (phase == 3);
         start = items;
         while (items - start < PHASE_ITEMS)
            send_random_packet();
         drain(phase == 5 ? DRAIN_CYCLES : SETTLE);
      end

      if (sb.errors == 0 && sb.pending() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
